### rtl/ifa_pkg.sv
package ifa_pkg;

  // heap geometry
  localparam int HEAP_WORDS = 64;
  localparam int ADDR_W     = $clog2(HEAP_WORDS);
  localparam int REQ_W      = 8;
  localparam int INIT_BYTES = HEAP_WORDS * 4;
  localparam int NEED_MAX   = ((2 ** REQ_W - 1) + 7) / 4 * 4;
  localparam int HDR_W      = $clog2(((INIT_BYTES > NEED_MAX) ? INIT_BYTES : NEED_MAX) + 2);
  localparam int STEP_W     = HDR_W - 2;
  localparam int SUM_W      = ((ADDR_W > STEP_W) ? ADDR_W : STEP_W) + 1;
  localparam int LIMIT      = HEAP_WORDS - 1;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [HDR_W-1:0]  hdr_t;
  typedef logic [SUM_W-1:0]  sum_t;

  // result codes
  typedef enum logic [1:0] {
    ST_ALLOC = 2'd0,
    ST_NOFIT = 2'd1,
    ST_FREED = 2'd2
  } status_t;

  // microprogram step addresses
  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_A_WALK,
    S_A_END,
    S_A_WRH,
    S_A_SPLIT,
    S_A_DONE,
    S_A_NOFIT,
    S_F_CUR,
    S_F_WR,
    S_F_RDN,
    S_F_CHK,
    S_F_MRG,
    S_F_ZERO,
    S_F_DONE
  } step_t;

  // header read source
  typedef enum logic [1:0] {
    RD_NONE,
    RD_START,
    RD_WALK,
    RD_NXT
  } rd_op_t;

  // header write
  typedef enum logic [2:0] {
    WR_NONE,
    WR_ALLOC,
    WR_SPLIT,
    WR_CUR,
    WR_MERGE,
    WR_ZERO
  } wr_op_t;

  // datapath register loads
  typedef enum logic [1:0] {
    LD_NONE,
    LD_WALK,
    LD_CUR,
    LD_NHDR
  } ld_op_t;

  // result word load
  typedef enum logic [1:0] {
    RES_NONE,
    RES_ALLOC,
    RES_NOFIT,
    RES_FREED
  } res_op_t;

  // jump conditions
  typedef enum logic [3:0] {
    C_ALWAYS,
    C_IN_ACC,
    C_OP_FREE,
    C_WALK_DONE,
    C_FIT,
    C_SPLIT,
    C_ADDR0,
    C_NXT_OUT,
    C_NXT_BUSY,
    C_OUT_FREE
  } cond_t;

  // one control word
  typedef struct packed {
    rd_op_t  rd;
    wr_op_t  wr;
    ld_op_t  ld;
    res_op_t res;
    cond_t   cond;
    step_t   jt;
    step_t   jf;
  } uword_t;

  function automatic uword_t make_uword(rd_op_t rd, wr_op_t wr, ld_op_t ld, res_op_t res,
                                        cond_t cond, step_t jt, step_t jf);
    uword_t w;
    w.rd   = rd;
    w.wr   = wr;
    w.ld   = ld;
    w.res  = res;
    w.cond = cond;
    w.jt   = jt;
    w.jf   = jf;
    return w;
  endfunction

  // control store: jump to jt when the condition holds, else to jf
  function automatic uword_t ucode(step_t s);
    uword_t w;
    case (s)
      S_IDLE:    w = make_uword(RD_NONE,  WR_NONE,  LD_NONE, RES_NONE,  C_IN_ACC,
                                S_DISP, S_IDLE);
      S_DISP:    w = make_uword(RD_START, WR_NONE,  LD_NONE, RES_NONE,  C_OP_FREE,
                                S_F_CUR, S_A_WALK);
      S_A_WALK:  w = make_uword(RD_WALK,  WR_NONE,  LD_WALK, RES_NONE,  C_WALK_DONE,
                                S_A_END, S_A_WALK);
      S_A_END:   w = make_uword(RD_NONE,  WR_NONE,  LD_NONE, RES_NONE,  C_FIT,
                                S_A_WRH, S_A_NOFIT);
      S_A_WRH:   w = make_uword(RD_NONE,  WR_ALLOC, LD_NONE, RES_NONE,  C_SPLIT,
                                S_A_SPLIT, S_A_DONE);
      S_A_SPLIT: w = make_uword(RD_NONE,  WR_SPLIT, LD_NONE, RES_NONE,  C_ALWAYS,
                                S_A_DONE, S_A_DONE);
      S_A_DONE:  w = make_uword(RD_NONE,  WR_NONE,  LD_NONE, RES_ALLOC, C_OUT_FREE,
                                S_IDLE, S_A_DONE);
      S_A_NOFIT: w = make_uword(RD_NONE,  WR_NONE,  LD_NONE, RES_NOFIT, C_OUT_FREE,
                                S_IDLE, S_A_NOFIT);
      S_F_CUR:   w = make_uword(RD_NONE,  WR_NONE,  LD_CUR,  RES_NONE,  C_ADDR0,
                                S_F_DONE, S_F_WR);
      S_F_WR:    w = make_uword(RD_NONE,  WR_CUR,   LD_NONE, RES_NONE,  C_NXT_OUT,
                                S_F_DONE, S_F_RDN);
      S_F_RDN:   w = make_uword(RD_NXT,   WR_NONE,  LD_NONE, RES_NONE,  C_ALWAYS,
                                S_F_CHK, S_F_CHK);
      S_F_CHK:   w = make_uword(RD_NONE,  WR_NONE,  LD_NHDR, RES_NONE,  C_NXT_BUSY,
                                S_F_DONE, S_F_MRG);
      S_F_MRG:   w = make_uword(RD_NONE,  WR_MERGE, LD_NONE, RES_NONE,  C_ALWAYS,
                                S_F_ZERO, S_F_ZERO);
      S_F_ZERO:  w = make_uword(RD_NONE,  WR_ZERO,  LD_NONE, RES_NONE,  C_ALWAYS,
                                S_F_DONE, S_F_DONE);
      S_F_DONE:  w = make_uword(RD_NONE,  WR_NONE,  LD_NONE, RES_FREED, C_OUT_FREE,
                                S_IDLE, S_F_DONE);
      default:   w = make_uword(RD_NONE,  WR_NONE,  LD_NONE, RES_NONE,  C_ALWAYS,
                                S_IDLE, S_IDLE);
    endcase
    return w;
  endfunction

endpackage

### rtl/ifa_req_if.sv
interface ifa_req_if;
  logic                             valid;
  logic                             ready;
  logic                             op;
  logic [ifa_pkg::REQ_W-1:0]        request_bytes;
  logic [ifa_pkg::ADDR_W-1:0]       block_address;

  modport source (output valid, output op, output request_bytes, output block_address,
                  input ready);
  modport sink   (input valid, input op, input request_bytes, input block_address,
                  output ready);
endinterface

### rtl/ifa_rsp_if.sv
interface ifa_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       status;
  logic [ifa_pkg::ADDR_W-1:0]       payload_address;

  modport source (output valid, output status, output payload_address, input ready);
  modport sink   (input valid, input status, input payload_address, output ready);
endinterface

### rtl/ifa_ram.sv
module ifa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/implicit_free_list_allocator.sv
// First-fit heap allocator over HEAP_WORDS words with one header word per block (size in
// bytes, bit 0 set while allocated). A word on in_req either allocates request_bytes plus a
// 4-byte header, rounded up to 4, or frees the block whose payload starts at block_address
// and merges it with the following block when that one is free. Each word gives one result
// word on out_rsp: status and, for a successful allocation, the payload word index. One word
// is worked on at a time and the headers sit in a memory with one write port and one
// registered read port, which the walk reads once per cycle. The block takes the next
// word as soon as the result is handed to the output register, even while that result waits.
module implicit_free_list_allocator (
  input  logic             clk,
  input  logic             rst_n,
  ifa_req_if.sink          in_req,
  ifa_rsp_if.source        out_rsp
);

  // sequencer
  ifa_pkg::step_t   upc_r, upc_nxt;
  ifa_pkg::uword_t  uw;
  logic             cond_true;

  // captured request
  logic             op_r;
  ifa_pkg::hdr_t    need_r;
  ifa_pkg::addr_t   addr_r;

  // datapath registers
  ifa_pkg::addr_t   ptr_r;
  ifa_pkg::hdr_t    hdr_r;
  ifa_pkg::hdr_t    nhdr_r;
  logic             fit_r;
  ifa_pkg::addr_t   nxt_r;
  logic             nxt_out_r;

  // header memory and its valid bits
  logic [ifa_pkg::HEAP_WORDS-1:0] valid_r;
  logic             rd_vld_r;
  logic             rd_w0_r;
  logic             ram_we, ram_re;
  ifa_pkg::addr_t   ram_waddr, ram_raddr;
  ifa_pkg::hdr_t    ram_wdata, ram_q;

  // result register
  logic             out_valid_r;
  ifa_pkg::status_t out_status_r;
  ifa_pkg::addr_t   out_addr_r;

  // datapath combinational values
  logic             in_acc;
  ifa_pkg::hdr_t    hdr_rd;
  logic [ifa_pkg::STEP_W-1:0] step_w;
  ifa_pkg::sum_t    walk_sum;
  logic             fit_w;
  logic             walk_done;
  ifa_pkg::addr_t   hi_w;
  ifa_pkg::hdr_t    cur_w;
  ifa_pkg::sum_t    nxt_sum;
  ifa_pkg::sum_t    split_sum;
  logic             split_in;
  logic             out_free;
  logic             res_ld;
  ifa_pkg::status_t res_status;
  ifa_pkg::addr_t   res_addr;

  assign uw     = ifa_pkg::ucode(upc_r);
  assign in_acc = in_req.valid && in_req.ready;

  // header as read, with never-written words showing their reset value
  always_comb begin
    if (rd_vld_r) begin
      hdr_rd = ram_q;
    end else if (rd_w0_r) begin
      hdr_rd = ifa_pkg::HDR_W'(ifa_pkg::INIT_BYTES);
    end else begin
      hdr_rd = '0;
    end
  end

  // walk arithmetic
  assign step_w    = hdr_rd[ifa_pkg::HDR_W-1:2];
  assign walk_sum  = ifa_pkg::SUM_W'(ptr_r) + ifa_pkg::SUM_W'(step_w);
  assign fit_w     = !hdr_rd[0] && (hdr_rd >= need_r);
  assign walk_done = fit_w || (step_w == '0) ||
                     (walk_sum >= ifa_pkg::SUM_W'(ifa_pkg::LIMIT));

  // free arithmetic
  assign hi_w    = addr_r - ifa_pkg::ADDR_W'(1);
  assign cur_w   = {hdr_rd[ifa_pkg::HDR_W-1:1], 1'b0};
  assign nxt_sum = ifa_pkg::SUM_W'(hi_w) + ifa_pkg::SUM_W'(cur_w[ifa_pkg::HDR_W-1:2]);

  // split position
  assign split_sum = ifa_pkg::SUM_W'(ptr_r) + ifa_pkg::SUM_W'(need_r[ifa_pkg::HDR_W-1:2]);
  assign split_in  = split_sum < ifa_pkg::SUM_W'(ifa_pkg::HEAP_WORDS);

  assign out_free = !out_valid_r || out_rsp.ready;

  // condition select
  always_comb begin
    case (uw.cond)
      ifa_pkg::C_ALWAYS:    cond_true = 1'b1;
      ifa_pkg::C_IN_ACC:    cond_true = in_acc;
      ifa_pkg::C_OP_FREE:   cond_true = op_r;
      ifa_pkg::C_WALK_DONE: cond_true = walk_done;
      ifa_pkg::C_FIT:       cond_true = fit_r;
      ifa_pkg::C_SPLIT:     cond_true = hdr_r > need_r;
      ifa_pkg::C_ADDR0:     cond_true = addr_r == '0;
      ifa_pkg::C_NXT_OUT:   cond_true = nxt_out_r;
      ifa_pkg::C_NXT_BUSY:  cond_true = hdr_rd[0];
      ifa_pkg::C_OUT_FREE:  cond_true = out_free;
      default:              cond_true = 1'b1;
    endcase
  end

  // next step
  always_comb begin
    upc_nxt = cond_true ? uw.jt : uw.jf;
  end

  // memory port decode
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = '0;
    case (uw.rd)
      ifa_pkg::RD_START: begin
        ram_re    = 1'b1;
        ram_raddr = op_r ? hi_w : '0;
      end
      ifa_pkg::RD_WALK: begin
        ram_re    = 1'b1;
        ram_raddr = walk_sum[ifa_pkg::ADDR_W-1:0];
      end
      ifa_pkg::RD_NXT: begin
        ram_re    = 1'b1;
        ram_raddr = nxt_r;
      end
      default: begin
        ram_re    = 1'b0;
        ram_raddr = '0;
      end
    endcase

    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    case (uw.wr)
      ifa_pkg::WR_ALLOC: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_r;
        ram_wdata = need_r + ifa_pkg::HDR_W'(1);
      end
      ifa_pkg::WR_SPLIT: begin
        ram_we    = split_in;
        ram_waddr = split_sum[ifa_pkg::ADDR_W-1:0];
        ram_wdata = hdr_r - need_r;
      end
      ifa_pkg::WR_CUR: begin
        ram_we    = 1'b1;
        ram_waddr = hi_w;
        ram_wdata = hdr_r;
      end
      ifa_pkg::WR_MERGE: begin
        ram_we    = 1'b1;
        ram_waddr = hi_w;
        ram_wdata = hdr_r + nhdr_r;
      end
      ifa_pkg::WR_ZERO: begin
        ram_we    = 1'b1;
        ram_waddr = nxt_r;
        ram_wdata = '0;
      end
      default: begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
      end
    endcase
  end

  // result decode
  always_comb begin
    res_ld     = (uw.res != ifa_pkg::RES_NONE) && cond_true;
    res_addr   = '0;
    case (uw.res)
      ifa_pkg::RES_ALLOC: begin
        res_status = ifa_pkg::ST_ALLOC;
        res_addr   = ptr_r + ifa_pkg::ADDR_W'(1);
      end
      ifa_pkg::RES_NOFIT: res_status = ifa_pkg::ST_NOFIT;
      ifa_pkg::RES_FREED: res_status = ifa_pkg::ST_FREED;
      default:            res_status = ifa_pkg::ST_FREED;
    endcase
  end

  ifa_ram #(
    .WIDTH (ifa_pkg::HDR_W),
    .DEPTH (ifa_pkg::HEAP_WORDS)
  ) u_hdr_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  // step counter, valid bits and result handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r       <= ifa_pkg::S_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      upc_r <= upc_nxt;
      if (ram_we) begin
        valid_r[ram_waddr] <= 1'b1;
      end
      if (res_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r   <= in_req.op;
      need_r <= (ifa_pkg::HDR_W'(in_req.request_bytes) + ifa_pkg::HDR_W'(7)) &
                ~ifa_pkg::HDR_W'(3);
      addr_r <= in_req.block_address;
      ptr_r  <= '0;
    end
    if (ram_re) begin
      rd_vld_r <= valid_r[ram_raddr];
      rd_w0_r  <= ram_raddr == '0;
    end
    case (uw.ld)
      ifa_pkg::LD_WALK: begin
        hdr_r <= hdr_rd;
        fit_r <= fit_w;
        if (!walk_done) begin
          ptr_r <= walk_sum[ifa_pkg::ADDR_W-1:0];
        end
      end
      ifa_pkg::LD_CUR: begin
        hdr_r     <= cur_w;
        nxt_r     <= nxt_sum[ifa_pkg::ADDR_W-1:0];
        nxt_out_r <= nxt_sum >= ifa_pkg::SUM_W'(ifa_pkg::HEAP_WORDS);
      end
      ifa_pkg::LD_NHDR: begin
        nhdr_r <= hdr_rd;
      end
      default: begin
      end
    endcase
    if (res_ld) begin
      out_status_r <= res_status;
      out_addr_r   <= res_addr;
    end
  end

  assign in_req.ready            = upc_r == ifa_pkg::S_IDLE;
  assign out_rsp.valid           = out_valid_r;
  assign out_rsp.status          = out_status_r;
  assign out_rsp.payload_address = out_addr_r;

  // an accepted word always enters dispatch
  a_acc_disp: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> upc_r == ifa_pkg::S_DISP)
    else $error("accepted word did not reach dispatch");

  // the walk never looks at a header at or past the search bound
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    upc_r == ifa_pkg::S_A_WALK |-> $past(upc_r) == ifa_pkg::S_DISP ||
                                   ptr_r < ifa_pkg::ADDR_W'(ifa_pkg::LIMIT))
    else $error("header walk past search bound");

  // no header write while waiting for a word
  a_idle_nowr: assert property (@(posedge clk) disable iff (!rst_n)
    upc_r == ifa_pkg::S_IDLE |-> !ram_we)
    else $error("header write while idle");

  // freed status for every free, and only for a free
  a_res_kind: assert property (@(posedge clk) disable iff (!rst_n)
    res_ld |-> ((res_status == ifa_pkg::ST_FREED) == op_r))
    else $error("result status does not match operation");

  // an allocated payload never starts at word zero
  a_alloc_addr: assert property (@(posedge clk) disable iff (!rst_n)
    res_ld && res_status == ifa_pkg::ST_ALLOC |-> res_addr != '0)
    else $error("allocation returned payload index zero");

endmodule

### dv/ifa_tb_pkg.sv
package ifa_tb_pkg;

  // request word operation
  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

endpackage

### dv/ifa_alloc_checker.sv
module ifa_alloc_checker (
  input  logic clk,
  input  logic rst_n,
  ifa_req_if   req_mon,
  ifa_rsp_if   rsp_mon,
  output int   error_cnt,
  output int   pending_cnt
);
  timeunit 1ns;
  timeprecision 1ps;

  import ifa_pkg::*;
  import ifa_tb_pkg::*;

  localparam int MAX_PRINTED = 20;

  typedef struct packed {
    status_t status;
    addr_t   addr;
  } alloc_rsp_t;

  // shadow copy of the header memory and the results still owed
  hdr_t       shadow_hdr [HEAP_WORDS];
  alloc_rsp_t rsp_owed_q [$];

  initial begin
    error_cnt   = 0;
    pending_cnt = 0;
  end

  task automatic report_mismatch(input string msg);
    error_cnt++;
    if (error_cnt <= MAX_PRINTED)
      $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  // first-fit walk, split, free and forward merge on the shadow headers
  function automatic alloc_rsp_t heap_update(input logic op, input logic [REQ_W-1:0] bytes,
                                             input addr_t baddr);
    alloc_rsp_t  r;
    int unsigned need, idx, stride, old_sz, split_at, hi, cur, nxt;
    logic        fit, stuck;
    r.status = ST_FREED;
    r.addr   = '0;
    if (op == OP_ALLOC) begin
      // payload plus header, rounded up to a whole word
      need  = (32'(bytes) + 32'd7) & ~32'd3;
      idx   = 0;
      fit   = 1'b0;
      stuck = 1'b0;
      while (idx < LIMIT && !fit && !stuck) begin
        if (!shadow_hdr[idx][0] && 32'(shadow_hdr[idx]) >= need) begin
          fit = 1'b1;
        end else begin
          stride = 32'(shadow_hdr[idx]) >> 2;
          // a zero-size header would never advance the walk
          if (stride == 0) stuck = 1'b1;
          else idx += stride;
        end
      end
      if (!fit) begin
        r.status = ST_NOFIT;
      end else begin
        old_sz          = 32'(shadow_hdr[idx]);
        shadow_hdr[idx] = hdr_t'(need + 1);
        if (old_sz > need) begin
          split_at = idx + (need >> 2);
          if (split_at < HEAP_WORDS) shadow_hdr[split_at] = hdr_t'(old_sz - need);
        end
        r.status = ST_ALLOC;
        r.addr   = addr_t'(idx + 1);
      end
    end else if (baddr != '0) begin
      // clear the allocated bit, then absorb the next block if it is free
      hi             = 32'(baddr) - 1;
      cur            = 32'(shadow_hdr[hi]);
      cur            = cur & ~32'd1;
      shadow_hdr[hi] = hdr_t'(cur);
      nxt            = hi + (cur >> 2);
      if (nxt < HEAP_WORDS && !shadow_hdr[nxt][0]) begin
        shadow_hdr[hi]  = hdr_t'(cur + 32'(shadow_hdr[nxt]));
        shadow_hdr[nxt] = '0;
      end
    end
    return r;
  endfunction

  // compare each result word with the oldest owed one, then predict new requests
  always @(posedge clk) begin : chk_seq
    alloc_rsp_t want;
    if (!rst_n) begin
      for (int i = 0; i < HEAP_WORDS; i++) shadow_hdr[i] = '0;
      shadow_hdr[0] = hdr_t'(INIT_BYTES);
      rsp_owed_q.delete();
    end else begin
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (rsp_owed_q.size() == 0) begin
          report_mismatch("result word with no request outstanding");
        end else begin
          want = rsp_owed_q.pop_front();
          if (rsp_mon.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      rsp_mon.status, want.status));
          if (rsp_mon.payload_address !== want.addr)
            report_mismatch($sformatf("payload address %0d, expected %0d",
                                      rsp_mon.payload_address, want.addr));
        end
      end
      if (req_mon.valid && req_mon.ready)
        rsp_owed_q.push_back(heap_update(req_mon.op, req_mon.request_bytes,
                                         req_mon.block_address));
    end
    pending_cnt = rsp_owed_q.size();
  end

endmodule

### dv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ifa_pkg::*;
  import ifa_tb_pkg::*;

  localparam int ITEM_TOTAL   = 1850;
  localparam int STEADY_FIRST = 900;
  localparam int STEADY_LAST  = 1150;
  localparam int HOLD_AT      = 500;
  localparam int HOLD_CYCLES  = 300;
  localparam int PAUSE_AT     = 1400;
  localparam int DRAIN_CYCLES = 100;
  localparam int IDLE_PCT     = 34;

  logic  clk;
  logic  rst_n;
  logic  steady;
  logic  hold_req;
  logic  hold_done = 1'b0;
  int    sent_cnt = 0;
  int    got_cnt = 0;
  int    alloc_seen = 0;
  int    nofit_seen = 0;
  int    freed_seen = 0;
  int    error_cnt;
  int    pending_cnt;
  addr_t live_q [$];
  addr_t last_freed = '0;

  ifa_req_if req_ch ();
  ifa_rsp_if rsp_ch ();

  implicit_free_list_allocator i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_rsp (rsp_ch)
  );

  ifa_alloc_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_mon     (req_ch),
    .rsp_mon     (rsp_ch),
    .error_cnt   (error_cnt),
    .pending_cnt (pending_cnt)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin
    #16_000_000;
    $display("implicit_free_list_allocator test failed");
    $finish;
  end

  // note result words mid-cycle, ahead of the edge that takes them
  always @(negedge clk) begin
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      got_cnt++;
      case (status_t'(rsp_ch.status))
        ST_ALLOC: begin
          alloc_seen++;
          live_q.push_back(rsp_ch.payload_address);
        end
        ST_NOFIT: nofit_seen++;
        default:  freed_seen++;
      endcase
    end
  end

  // result side: random stalls, one long hold-off, none while steady
  initial begin
    rsp_ch.ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        rsp_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        @(posedge clk);
      end
    end
  end

  task automatic send_word(input op_t op, input logic [REQ_W-1:0] bytes, input addr_t baddr);
    if (!steady)
      while ($urandom_range(99) < IDLE_PCT) begin
        req_ch.valid <= 1'b0;
        @(posedge clk);
      end
    req_ch.valid         <= 1'b1;
    req_ch.op            <= op;
    req_ch.request_bytes <= bytes;
    req_ch.block_address <= baddr;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sent_cnt <= sent_cnt + 1;
  endtask

  // unused fields carry random bits
  task automatic alloc_req(input logic [REQ_W-1:0] bytes);
    send_word(OP_ALLOC, bytes, addr_t'($urandom));
  endtask

  task automatic free_req(input addr_t baddr);
    send_word(OP_FREE, REQ_W'($urandom), baddr);
  endtask

  task automatic hold_until_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (got_cnt != sent_cnt) @(posedge clk);
  endtask

  // stimulus
  initial begin
    int               pick;
    int               slot;
    logic [REQ_W-1:0] bytes;
    rst_n                <= 1'b0;
    steady               <= 1'b0;
    hold_req             <= 1'b0;
    req_ch.valid         <= 1'b0;
    req_ch.op            <= OP_ALLOC;
    req_ch.request_bytes <= '0;
    req_ch.block_address <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // smallest block, then a miss on an oversized request, merge back
    alloc_req(0);
    alloc_req(252);
    free_req(1);
    // whole heap in one block, nothing left for even the smallest request
    alloc_req(252);
    alloc_req(0);
    free_req(1);
    free_req(0);
    // walk that runs into the last header word
    alloc_req(1);
    alloc_req(244);
    alloc_req(0);
    free_req(3);
    alloc_req(236);
    alloc_req(0);
    alloc_req(0);
    // merges, free of a block already free, self merge on zero headers
    free_req(63);
    free_req(1);
    free_req(3);
    free_req(1);
    free_req(5);
    free_req(63);
    // split in the middle, near miss, exact fit at the top
    alloc_req(128);
    alloc_req(127);
    alloc_req(120);
    free_req(1);
    free_req(34);
    hold_until_drained();
    live_q.delete();

    // mostly alloc and free of live blocks, some stray and repeated frees
    for (int n = 0; n < ITEM_TOTAL; n++) begin
      steady <= (n >= STEADY_FIRST && n < STEADY_LAST);
      if (n == HOLD_AT) hold_req <= 1'b1;
      if (n == PAUSE_AT) hold_until_drained();
      pick = $urandom_range(99);
      if (pick < 45 || (pick < 85 && live_q.size() == 0)) begin
        slot = $urandom_range(99);
        if (slot < 80) bytes = REQ_W'($urandom_range(40));
        else if (slot < 95) bytes = REQ_W'($urandom_range(128, 41));
        else bytes = REQ_W'($urandom_range(252, 129));
        alloc_req(bytes);
      end else if (pick < 85) begin
        slot       = $urandom_range(live_q.size() - 1);
        last_freed = live_q[slot];
        live_q.delete(slot);
        free_req(last_freed);
      end else if (pick < 93) begin
        free_req(addr_t'($urandom_range(63)));
      end else begin
        free_req(last_freed);
      end
    end

    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d request words: %0d allocations, %0d no-fit answers, %0d frees",
             sent_cnt, alloc_seen, nofit_seen, freed_seen);
    $display("included a %0d-cycle output hold-off and a drained pause", HOLD_CYCLES);
    if (error_cnt == 0 && pending_cnt == 0)
      $display("implicit_free_list_allocator test passed");
    else
      $display("implicit_free_list_allocator test failed");
    $finish;
  end

endmodule
